### sv/ffba_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ffba_pkg
// Shared constants of the first-fit block allocator.
// ----------------------------------------------------------------------------
package ffba_pkg;
    localparam int MAX_BLOCKS_DEF = 32;
    localparam int ADDR_BITS_DEF  = 16;

    localparam logic [2:0] ST_OK           = 3'd0;
    localparam logic [2:0] ST_NO_FIT       = 3'd1;
    localparam logic [2:0] ST_INVALID_FREE = 3'd2;
    localparam logic [2:0] ST_TABLE_FULL   = 3'd3;
    localparam logic [2:0] ST_ZERO_REQUEST = 3'd4;

    localparam logic ACT_ALLOC = 1'b0;
    localparam logic ACT_FREE  = 1'b1;
endpackage
`default_nettype wire

### sv/ffba_table.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ffba_table
// Block table memory: one write port, one read port, registered read data.
// An entry holds {used, size, offset}.
// ----------------------------------------------------------------------------
module ffba_table
    import ffba_pkg::*;
#(
    parameter int DEPTH = MAX_BLOCKS_DEF,
    parameter int WIDTH = 34
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule
`default_nettype wire

### sv/first_fit_block_allocator.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// first_fit_block_allocator
// First-fit allocator with coalescing over an address-ordered block table.
// ----------------------------------------------------------------------------
// Usage: requests enter on the s_axis channel (tuser = action, tdata =
// request_bytes, then free_offset, from bit 0 up). Each request yields one
// result item on m_axis (tdata = block_offset, then status, from bit 0 up).
// One request at a time: the table, kept in a memory with one registered read
// port, is scanned one entry per cycle after an initial read start. An exact
// fit is marked used in place; a larger hit is split, moving later entries
// up, and a free merges with free neighbours, moving later entries down.
// A zero-byte allocate skips the scan and goes straight to the output
// state. The next request is taken only once the result has left.
// Reset, or a write of i_cfg_wdata, sets the table to one free block at
// offset 0 covering the pool; no clearing pass is needed since only the
// block count marks valid entries. When the receiver stalls the result is
// held in the output register and no new request is taken until it leaves.
// ----------------------------------------------------------------------------
module first_fit_block_allocator
    import ffba_pkg::*;
#(
    parameter int MAX_BLOCKS = MAX_BLOCKS_DEF
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_cfg_we,
    input  wire logic [23:0] i_cfg_wdata,   // total_size[16:0]
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [39:0] s_axis_tdata,  // request_bytes[16:0], free_offset[32:17]
    input  wire logic        s_axis_tuser,  // action
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [23:0]      m_axis_tdata   // block_offset[15:0], status[18:16]
);
    localparam int ADDR_BITS = ADDR_BITS_DEF;
    localparam int IW = $clog2(MAX_BLOCKS);
    localparam int CW = $clog2(MAX_BLOCKS + 1);
    localparam int SW = ADDR_BITS + 1;
    localparam int EW = 1 + SW + ADDR_BITS;
    localparam logic [SW-1:0] LIMIT = SW'(1) << ADDR_BITS;

    typedef enum logic [8:0] {
        S_IDLE  = 9'b000000001,
        S_SCAN  = 9'b000000010,
        S_SPLIT = 9'b000000100,
        S_MVUP  = 9'b000001000,
        S_NBR   = 9'b000010000,
        S_PREV  = 9'b000100000,
        S_MVDN  = 9'b001000000,
        S_FIX   = 9'b010000000,
        S_OUT   = 9'b100000000
    } t_state;

    t_state r_state;
    logic [CW-1:0] r_count;
    logic [IW-1:0] r_idx;       // scan index of the entry in flight
    logic [IW-1:0] r_hit;
    logic          r_rd_ok;     // read data valid for r_idx
    logic          r_act;
    logic [SW-1:0] r_req;
    logic [ADDR_BITS-1:0] r_foff;
    logic [EW-1:0] r_cur;       // the chosen entry
    logic [EW-1:0] r_newe;      // entry to insert / merged entry
    logic [IW-1:0] r_mv;        // move pointer
    logic          r_mv_ph;
    logic [1:0]    r_rm;        // entries to remove on merge
    logic [IW-1:0] r_rm_at;
    logic [ADDR_BITS-1:0] r_ooff;
    logic [2:0]    r_ost;
    logic          r_ovalid;
    logic          r_cfg_pend;
    logic [SW-1:0] r_total;

    logic          we;
    logic [IW-1:0] waddr, raddr;
    logic [EW-1:0] wdata, rdata;

    ffba_table #(.DEPTH(MAX_BLOCKS), .WIDTH(EW)) u_table (
        .i_clk(i_clk), .i_we(we), .i_waddr(waddr), .i_wdata(wdata),
        .i_raddr(raddr), .o_rdata(rdata)
    );

    logic          rd_used;
    logic [SW-1:0] rd_size;
    logic [ADDR_BITS-1:0] rd_off;
    assign rd_used = rdata[EW-1];
    assign rd_size = rdata[EW-2 -: SW];
    assign rd_off  = rdata[ADDR_BITS-1:0];

    logic [16:0] cfg_v;
    logic [SW-1:0] cfg_clamped;
    assign cfg_v = i_cfg_wdata[16:0];
    always_comb begin
        if (cfg_v == 17'd0) begin
            cfg_clamped = SW'(1);
        end else if ({15'd0, cfg_v} > {{(32-SW){1'b0}}, LIMIT}) begin
            cfg_clamped = LIMIT;
        end else begin
            cfg_clamped = SW'(cfg_v);
        end
    end

    logic [CW-1:0] idx_ext;
    logic          last_idx;
    logic          match;
    assign idx_ext  = CW'(r_idx);
    assign last_idx = (idx_ext + CW'(1) >= r_count);
    assign match = (r_act == ACT_ALLOC) ? (!rd_used && rd_size >= r_req)
                                        : (rd_used && rd_off == r_foff);

    assign s_axis_tready = (r_state == S_IDLE) && !r_ovalid && !r_cfg_pend;
    assign m_axis_tvalid = r_ovalid;
    assign m_axis_tdata  = {5'd0, r_ost, 16'(r_ooff)};

    // Merge tracking read at the neighbor steps.
    logic r_next_free;

    always_comb begin
        we = 1'b0;
        waddr = r_idx;
        wdata = r_newe;
        raddr = r_idx;
        case (r_state)
            S_IDLE:  raddr = '0;
            S_SCAN:  raddr = r_rd_ok ? IW'(r_idx + IW'(1)) : r_idx;
            S_MVUP:  raddr = r_mv;
            S_NBR:   raddr = IW'(r_hit + IW'(1));
            S_PREV:  raddr = IW'(r_hit - IW'(1));
            S_MVDN:  raddr = IW'(r_mv + IW'(r_rm));
            default: raddr = r_idx;
        endcase
        if (r_cfg_pend) begin
            we = 1'b1;
            waddr = '0;
            wdata = {1'b0, r_total, {ADDR_BITS{1'b0}}};
        end else begin
            case (r_state)
                S_SPLIT: begin
                    we = 1'b1;
                    waddr = r_hit;
                    wdata = {1'b1, r_req, r_cur[ADDR_BITS-1:0]};
                end
                S_MVUP: if (r_mv_ph) begin
                    we = 1'b1;
                    waddr = IW'(r_mv + IW'(1));
                    wdata = rdata;
                end
                S_MVDN: if (r_mv_ph) begin
                    we = 1'b1;
                    waddr = r_mv;
                    wdata = rdata;
                end
                S_FIX: begin
                    we = 1'b1;
                    waddr = r_rm_at;
                    wdata = r_newe;
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= CW'(1);
            r_ovalid <= 1'b0;
            r_cfg_pend <= 1'b1;
            r_total <= LIMIT;
            r_rd_ok <= 1'b0;
            r_mv_ph <= 1'b0;
        end else begin
            if (r_ovalid && m_axis_tready) r_ovalid <= 1'b0;
            if (i_cfg_we) begin
                r_total <= cfg_clamped;
                r_cfg_pend <= 1'b1;
                r_count <= CW'(1);
            end else if (r_cfg_pend) begin
                r_cfg_pend <= 1'b0;
            end
            case (r_state)
                S_IDLE: if (s_axis_tvalid && s_axis_tready) begin
                    r_act  <= s_axis_tuser;
                    r_req  <= SW'(s_axis_tdata[16:0]);
                    r_foff <= ADDR_BITS'(s_axis_tdata[32:17]);
                    r_idx  <= '0;
                    r_rd_ok <= 1'b0;
                    if (s_axis_tuser == ACT_ALLOC && s_axis_tdata[16:0] == 17'd0) begin
                        r_ost <= ST_ZERO_REQUEST;
                        r_ooff <= '0;
                        r_state <= S_OUT;
                    end else begin
                        r_state <= S_SCAN;
                    end
                end
                S_SCAN: begin
                    if (!r_rd_ok) begin
                        r_rd_ok <= 1'b1;
                    end else if (match) begin
                        r_hit <= r_idx;
                        r_cur <= rdata;
                        r_rd_ok <= 1'b0;
                        if (r_act == ACT_ALLOC) begin
                            if (rd_size == r_req) begin
                                r_ooff <= rd_off;
                                r_newe <= {1'b1, rd_size, rd_off};
                                r_rm_at <= r_idx;
                                r_ost <= ST_OK;
                                r_state <= S_FIX;
                            end else if (r_count >= CW'(MAX_BLOCKS)) begin
                                r_ost <= ST_TABLE_FULL;
                                r_ooff <= '0;
                                r_state <= S_OUT;
                            end else begin
                                r_ooff <= rd_off;
                                r_state <= S_SPLIT;
                            end
                        end else begin
                            r_ooff <= '0;
                            r_ost <= ST_OK;
                            r_state <= S_NBR;
                        end
                    end else if (last_idx) begin
                        r_ost <= (r_act == ACT_ALLOC) ? ST_NO_FIT : ST_INVALID_FREE;
                        r_ooff <= '0;
                        r_state <= S_OUT;
                    end else begin
                        r_idx <= IW'(r_idx + IW'(1));
                    end
                end
                S_SPLIT: begin
                    // Remainder goes in at r_hit+1; shift the tail up first.
                    r_newe <= {1'b0, SW'(r_cur[EW-2 -: SW] - r_req),
                               ADDR_BITS'(r_cur[ADDR_BITS-1:0] + ADDR_BITS'(r_req))};
                    r_rm_at <= IW'(r_hit + IW'(1));
                    r_ost <= ST_OK;
                    r_mv <= IW'(r_count - CW'(1));
                    r_mv_ph <= 1'b0;
                    r_state <= (IW'(r_count - CW'(1)) == r_hit) ? S_FIX : S_MVUP;
                end
                S_MVUP: begin
                    if (!r_mv_ph) begin
                        r_mv_ph <= 1'b1;
                    end else begin
                        r_mv_ph <= 1'b0;
                        if (IW'(r_mv - IW'(1)) == r_hit) begin
                            r_state <= S_FIX;
                        end else begin
                            r_mv <= IW'(r_mv - IW'(1));
                        end
                    end
                end
                S_NBR: begin
                    // Read of the next entry issued; decide next cycle.
                    r_state <= S_PREV;
                    r_rm <= '0;
                end
                S_PREV: begin
                    logic has_next;
                    logic [SW-1:0] sz;
                    has_next = (CW'(r_hit) + CW'(1) < r_count);
                    sz = r_cur[EW-2 -: SW];
                    r_next_free <= has_next && !rd_used;
                    if (has_next && !rd_used) begin
                        r_cur <= {1'b0, SW'(sz + rd_size), r_cur[ADDR_BITS-1:0]};
                    end else begin
                        r_cur <= {1'b0, sz, r_cur[ADDR_BITS-1:0]};
                    end
                    r_state <= S_MVDN;
                    r_mv_ph <= 1'b0;
                    r_rm <= 2'd3;   // marks "previous not yet seen"
                end
                S_MVDN: begin
                    if (r_rm == 2'd3) begin
                        // rdata is the previous entry now.
                        logic prev_free;
                        logic [1:0] n_rm;
                        prev_free = (r_hit != '0) && !rd_used;
                        n_rm = 2'(r_next_free) + 2'(prev_free);
                        if (prev_free) begin
                            r_newe <= {1'b0, SW'(rd_size + r_cur[EW-2 -: SW]),
                                       rd_off};
                            r_rm_at <= IW'(r_hit - IW'(1));
                            r_mv <= r_hit;
                        end else begin
                            r_newe <= r_cur;
                            r_rm_at <= r_hit;
                            r_mv <= IW'(r_hit + IW'(1));
                        end
                        r_rm <= n_rm;
                        r_count <= r_count - CW'(n_rm);
                        if (n_rm == 2'd0 ||
                            CW'(prev_free ? r_hit : IW'(r_hit + IW'(1))) + CW'(n_rm)
                                >= r_count) begin
                            r_state <= S_FIX;
                        end
                    end else if (!r_mv_ph) begin
                        r_mv_ph <= 1'b1;
                    end else begin
                        r_mv_ph <= 1'b0;
                        if (CW'(r_mv) + CW'(1) + CW'(r_rm) >= r_count + CW'(r_rm)) begin
                            r_state <= S_FIX;
                        end else begin
                            r_mv <= IW'(r_mv + IW'(1));
                        end
                    end
                end
                S_FIX: begin
                    if (r_act == ACT_ALLOC && r_rm_at != r_hit) begin
                        r_count <= r_count + CW'(1);
                    end
                    r_state <= S_OUT;
                end
                S_OUT: if (!r_ovalid) begin
                    r_ovalid <= 1'b1;
                    r_state <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    ap_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count >= CW'(1) && r_count <= CW'(MAX_BLOCKS))
        else $error("block count out of range");
    ap_no_take_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tready |-> !r_ovalid && r_state == S_IDLE)
        else $error("request taken while busy");
    ap_out_once: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_OUT && !r_ovalid) |=> r_ovalid)
        else $error("result not presented");
endmodule
`default_nettype wire

### test/ffba_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ffba_checker
// Watches the allocator's channels, predicts each result from a behavioral
// copy of the block table, and compares the results field by field.
// ----------------------------------------------------------------------------
module ffba_checker
    import ffba_pkg::*;
#(
    parameter int NBLK = MAX_BLOCKS_DEF
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_cfg_we,
    input  wire logic [23:0] i_cfg_wdata,
    input  wire logic        i_s_tvalid,
    input  wire logic        i_s_tready,
    input  wire logic [39:0] i_s_tdata,
    input  wire logic        i_s_tuser,
    input  wire logic        i_m_tvalid,
    input  wire logic        i_m_tready,
    input  wire logic [23:0] i_m_tdata,
    output int               o_fail_count,
    output int               o_pending,
    output logic [4:0]       o_status_seen
);
    typedef struct packed {
        logic [15:0] offset;
        logic [2:0]  status;
    } t_alloc_result;

    logic [16:0] pool_size;
    logic [15:0] blk_off  [NBLK];
    logic [16:0] blk_size [NBLK];
    logic        blk_used [NBLK];
    int          blk_count;
    t_alloc_result expected_q[$];

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("mismatch: %s got %0d expected %0d at %0t", what, got, want, $realtime);
        o_fail_count++;
    endtask

    task automatic table_clear(input logic [16:0] sz);
        pool_size = sz;
        for (int i = 0; i < NBLK; i++) begin
            blk_off[i]  = '0;
            blk_size[i] = '0;
            blk_used[i] = 1'b0;
        end
        blk_size[0] = sz;
        blk_count   = 1;
    endtask

    task automatic drop_entry(input int idx);
        for (int i = idx; i + 1 < blk_count; i++) begin
            blk_off[i]  = blk_off[i+1];
            blk_size[i] = blk_size[i+1];
            blk_used[i] = blk_used[i+1];
        end
        blk_count--;
    endtask

    function automatic logic [16:0] clamp_pool(input logic [16:0] v);
        if (v == 0) return 17'd1;
        if (v > 17'd65536) return 17'd65536;
        return v;
    endfunction

    // Applies one request to the table and returns the result it yields.
    task automatic apply_request(input logic act, input logic [16:0] req,
                                 input logic [15:0] foff, output t_alloc_result res);
        bit done;
        res  = '{offset: '0, status: ST_NO_FIT};
        done = 0;
        if (act == ACT_ALLOC) begin
            if (req == 0) begin
                res.status = ST_ZERO_REQUEST;
            end else begin
                for (int i = 0; i < blk_count && !done; i++) begin
                    if (!blk_used[i] && blk_size[i] >= req) begin
                        done = 1;
                        if (blk_size[i] > req && blk_count >= NBLK) begin
                            res.status = ST_TABLE_FULL;
                        end else begin
                            if (blk_size[i] > req) begin
                                for (int j = blk_count; j > i + 1; j--) begin
                                    blk_off[j]  = blk_off[j-1];
                                    blk_size[j] = blk_size[j-1];
                                    blk_used[j] = blk_used[j-1];
                                end
                                blk_off[i+1]  = blk_off[i] + req[15:0];
                                blk_size[i+1] = blk_size[i] - req;
                                blk_used[i+1] = 1'b0;
                                blk_count++;
                                blk_size[i] = req;
                            end
                            blk_used[i] = 1'b1;
                            res = '{offset: blk_off[i], status: ST_OK};
                        end
                    end
                end
            end
        end else begin
            res.status = ST_INVALID_FREE;
            for (int i = 0; i < blk_count && !done; i++) begin
                if (blk_used[i] && blk_off[i] == foff) begin
                    done = 1;
                    res.status = ST_OK;
                    blk_used[i] = 1'b0;
                    if (i + 1 < blk_count && !blk_used[i+1]) begin
                        blk_size[i] += blk_size[i+1];
                        drop_entry(i + 1);
                    end
                    if (i > 0 && !blk_used[i-1]) begin
                        blk_size[i-1] += blk_size[i];
                        drop_entry(i);
                    end
                end
            end
        end
    endtask

    initial begin
        o_fail_count  = 0;
        o_status_seen = '0;
        table_clear(17'd65536);
    end

    always @(posedge i_clk) begin
        t_alloc_result res;
        t_alloc_result want;
        if (!i_rst_n) begin
            table_clear(17'd65536);
            expected_q.delete();
        end else begin
            if (i_m_tvalid && i_m_tready) begin
                if (expected_q.size() == 0) begin
                    report_mismatch("unexpected result item", 32'(i_m_tdata), 32'd0);
                end else begin
                    want = expected_q.pop_front();
                    if (i_m_tdata[18:16] <= ST_ZERO_REQUEST)
                        o_status_seen[i_m_tdata[18:16]] = 1'b1;
                    if (i_m_tdata[18:16] != want.status)
                        report_mismatch("status", 32'(i_m_tdata[18:16]),
                                        32'(want.status));
                    if (i_m_tdata[15:0] != want.offset)
                        report_mismatch("block_offset", 32'(i_m_tdata[15:0]),
                                        32'(want.offset));
                end
            end
            if (i_cfg_we)
                table_clear(clamp_pool(i_cfg_wdata[16:0]));
            if (i_s_tvalid && i_s_tready) begin
                apply_request(i_s_tuser, i_s_tdata[16:0], i_s_tdata[32:17], res);
                expected_q = {expected_q, res};
            end
        end
        o_pending = expected_q.size();
    end
endmodule

### test/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Drives allocate and free requests into the first-fit allocator across
// several pool sizes and handshake pressures; the checker judges results.
// ----------------------------------------------------------------------------
module tb;
    import ffba_pkg::*;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_cfg_we = 1'b0;
    logic [23:0] i_cfg_wdata = '0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [39:0] s_axis_tdata = '0;
    logic        s_axis_tuser = 1'b0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [23:0] m_axis_tdata;

    int          fail_count;
    int          pending;
    logic [4:0]  status_seen;
    int          idle_send = 28;
    int          idle_recv = 76;
    int          item_count = 0;
    logic [16:0] cur_pool = 17'd65536;
    logic        action_q[$];
    logic [15:0] live_offsets[$];

    always #5 i_clk = ~i_clk;

    first_fit_block_allocator dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_cfg_we(i_cfg_we), .i_cfg_wdata(i_cfg_wdata),
        .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata)
    );

    ffba_checker chk (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_cfg_we(i_cfg_we), .i_cfg_wdata(i_cfg_wdata),
        .i_s_tvalid(s_axis_tvalid), .i_s_tready(s_axis_tready),
        .i_s_tdata(s_axis_tdata), .i_s_tuser(s_axis_tuser),
        .i_m_tvalid(m_axis_tvalid), .i_m_tready(m_axis_tready),
        .i_m_tdata(m_axis_tdata),
        .o_fail_count(fail_count), .o_pending(pending), .o_status_seen(status_seen)
    );

    always @(posedge i_clk)
        m_axis_tready <= ($urandom_range(99) >= idle_recv);

    // Track offsets that were handed out so that most frees name a live block.
    always @(posedge i_clk) begin
        logic act;
        if (i_rst_n) begin
            if (m_axis_tvalid && m_axis_tready && action_q.size() > 0) begin
                act = action_q.pop_front();
                if (act == ACT_ALLOC && m_axis_tdata[18:16] == ST_OK)
                    live_offsets = {live_offsets, m_axis_tdata[15:0]};
            end
            if (s_axis_tvalid && s_axis_tready)
                action_q = {action_q, s_axis_tuser};
        end
    end

    task automatic send_request(input logic act, input logic [16:0] req,
                                input logic [15:0] foff);
        while ($urandom_range(99) < idle_send) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= act;
        s_axis_tdata  <= {7'd0, foff, req};
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        item_count++;
    endtask

    // Waits for the block to drain, then writes a new pool size.
    task automatic set_pool(input logic [16:0] sz);
        s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (200) @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= {7'd0, sz};
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        live_offsets.delete();
        cur_pool = (sz == 0) ? 17'd1 : (sz > 17'd65536 ? 17'd65536 : sz);
        @(posedge i_clk);
    endtask

    task automatic random_phase(input int count);
        int          pick;
        int          k;
        logic [16:0] req;
        logic [15:0] off;
        for (int n = 0; n < count; n++) begin
            pick = $urandom_range(99);
            if (pick < 40 && live_offsets.size() > 0) begin
                k   = $urandom_range(live_offsets.size() - 1);
                off = live_offsets[k];
                live_offsets.delete(k);
                send_request(ACT_FREE, 17'($urandom), off);
            end else if (pick < 45) begin
                send_request(ACT_FREE, 17'($urandom), 16'($urandom));
            end else begin
                pick = $urandom_range(99);
                if (pick < 4)       req = 17'd0;
                else if (pick < 8)  req = 17'($urandom);
                else if (pick < 12) req = cur_pool;
                else if (pick < 14) req = 17'd65536;
                else                req = 17'($urandom_range(1, cur_pool / 8 + 1));
                send_request(ACT_ALLOC, req, 16'($urandom));
            end
        end
    endtask

    initial begin
        logic [16:0] pools[6];
        pools = '{17'd0, 17'd131071, 17'd4096, 17'd65535, 17'd300, 17'd1};
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: zero request, exact fit, no fit, double free, merges.
        send_request(ACT_ALLOC, 17'd0, 16'hFFFF);
        send_request(ACT_ALLOC, 17'd65536, 16'd0);
        send_request(ACT_ALLOC, 17'd1, 16'd0);
        send_request(ACT_ALLOC, 17'h1FFFF, 16'd0);
        send_request(ACT_FREE, 17'h1FFFF, 16'd0);
        send_request(ACT_FREE, 17'd0, 16'd0);
        send_request(ACT_ALLOC, 17'd1, 16'd0);
        send_request(ACT_ALLOC, 17'd2, 16'd0);
        send_request(ACT_ALLOC, 17'd65533, 16'd0);
        send_request(ACT_ALLOC, 17'd1, 16'd0);
        send_request(ACT_FREE, 17'd0, 16'd1);
        send_request(ACT_FREE, 17'd0, 16'd0);
        send_request(ACT_FREE, 17'd0, 16'd3);
        send_request(ACT_FREE, 17'd0, 16'hFFFF);
        send_request(ACT_ALLOC, 17'd65535, 16'd0);
        send_request(ACT_ALLOC, 17'd1, 16'd0);
        send_request(ACT_FREE, 17'd0, 16'd0);
        send_request(ACT_FREE, 17'd0, 16'hFFFF);

        for (int p = 0; p < 6; p++) begin
            set_pool(pools[p]);
            case (p / 2)
                0: begin idle_send = 28; idle_recv = 76; end
                1: begin idle_send = 76; idle_recv = 28; end
                default: begin idle_send = 0; idle_recv = 0; end
            endcase
            random_phase(p == 5 ? 40 : 110);
        end
        s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (200) @(posedge i_clk);

        $display("Sent %0d requests over seven pool settings under three handshake pressures.",
                 item_count);
        $display("Result codes observed (bit per status): %b", status_seen);
        if (fail_count == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

    initial begin
        #10ms;
        $display("TB_ERROR");
        $finish;
    end
endmodule
